### hdl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types, constants and command codes for the min-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

  // Default stack depth
  localparam int unsigned STACK_DEPTH_DEF = 64;

  // Minimum reported by an empty stack (largest positive 32-bit integer)
  localparam logic signed [31:0] MIN_OF_EMPTY = 32'sh7FFF_FFFF;
  // Top value reported by an empty stack
  localparam logic signed [31:0] TOP_OF_EMPTY = 32'sh0000_0000;

  // Request types
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Fault codes
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_FULL  = 2'd1;
  localparam logic [1:0] FAULT_EMPTY = 2'd2;

  // Input transfer payload
  typedef struct packed {
    logic              req_type;
    logic signed [31:0] push_value;
  } req_t;

  // Result transfer payload
  typedef struct packed {
    logic signed [31:0] top_value;
    logic signed [31:0] min_value;
    logic               is_empty;
    logic [1:0]         fault;
  } res_t;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_PUSH,        // push with room left
    CMD_PUSH_FULL,   // push on full stack, dropped
    CMD_POP_READ,    // pop with two or more entries, fetch new top from memory
    CMD_POP_LAST,    // pop of the only entry
    CMD_POP_EMPTY,   // pop on empty stack, ignored
    CMD_POP_FINISH   // load fetched entry as new top
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic empty;
    logic one;
    logic full;
    logic out_free;
  } dp_status_t;

endpackage

### hdl/mts_datapath.sv
// ----------------------------------------------------------------------------
// mts_datapath
// Entry memory, entry count, cached top entry and result register.
// ----------------------------------------------------------------------------
module mts_datapath #(
  parameter int unsigned STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mts_pkg::dp_cmd_t    cmd,
  input  mts_pkg::req_t       req,
  output mts_pkg::dp_status_t status,
  output logic                out_valid,
  input  logic                out_stall,
  output mts_pkg::res_t       out_data
);
  import mts_pkg::*;

  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  typedef struct packed {
    logic signed [31:0] min_value;
    logic signed [31:0] value;
  } entry_t;

  // Entries below the top; the top entry lives in registers
  entry_t mem [STACK_DEPTH];
  entry_t rd_data_r;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic signed [31:0] top_val_r, top_val_nxt;
  logic signed [31:0] top_min_r, top_min_nxt;
  res_t               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0]   cnt_minus1;
  logic [CNT_W-1:0]   cnt_minus2;
  logic               wr_en;
  logic               rd_en;
  logic               load;
  logic signed [31:0] prev_min;
  logic signed [31:0] push_min;

  assign cnt_minus1 = count_r - CNT_W'(1);
  assign cnt_minus2 = count_r - CNT_W'(2);

  // Status toward the controller
  assign status.empty    = (count_r == '0);
  assign status.one      = (count_r == CNT_W'(1));
  assign status.full     = (count_r == CNT_W'(STACK_DEPTH));
  assign status.out_free = !out_valid_r || !out_stall;

  // Running minimum for a push
  assign prev_min = status.empty ? MIN_OF_EMPTY : top_min_r;
  assign push_min = (req.push_value < prev_min) ? req.push_value : prev_min;

  // Old top spills to memory on push; next entry fetched on pop
  assign wr_en = (cmd.op == CMD_PUSH) && !status.empty;
  assign rd_en = (cmd.op == CMD_POP_READ);

  // Next state and result
  always_comb begin
    count_nxt   = count_r;
    top_val_nxt = top_val_r;
    top_min_nxt = top_min_r;
    res_nxt     = res_r;
    load        = 1'b0;
    case (cmd.op)
      CMD_PUSH: begin
        count_nxt   = count_r + CNT_W'(1);
        top_val_nxt = req.push_value;
        top_min_nxt = push_min;
        res_nxt     = '{req.push_value, push_min, 1'b0, FAULT_NONE};
        load        = 1'b1;
      end
      CMD_PUSH_FULL: begin
        res_nxt = '{top_val_r, top_min_r, 1'b0, FAULT_FULL};
        load    = 1'b1;
      end
      CMD_POP_READ: begin
        count_nxt = cnt_minus1;
      end
      CMD_POP_LAST: begin
        count_nxt = '0;
        res_nxt   = '{TOP_OF_EMPTY, MIN_OF_EMPTY, 1'b1, FAULT_NONE};
        load      = 1'b1;
      end
      CMD_POP_EMPTY: begin
        res_nxt = '{TOP_OF_EMPTY, MIN_OF_EMPTY, 1'b1, FAULT_EMPTY};
        load    = 1'b1;
      end
      CMD_POP_FINISH: begin
        top_val_nxt = rd_data_r.value;
        top_min_nxt = rd_data_r.min_value;
        res_nxt     = '{rd_data_r.value, rd_data_r.min_value, 1'b0, FAULT_NONE};
        load        = 1'b1;
      end
      default: begin
      end
    endcase
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top_val_r <= top_val_nxt;
    top_min_r <= top_min_nxt;
    res_r     <= res_nxt;
  end

  // Entry memory, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_minus1[IDX_W-1:0]] <= '{top_min_r, top_val_r};
    end
    if (rd_en) begin
      rd_data_r <= mem[cnt_minus2[IDX_W-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // Count never passes the depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("entry count above stack depth");

  // A result is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> status.out_free)
    else $error("result loaded over an unread result");

  // A successful push leaves the stack non-empty
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == CMD_PUSH |=> count_r != '0)
    else $error("stack empty after push");

endmodule

### hdl/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// Request sequencer: decodes each request into a datapath operation and
// waits out the memory read of a pop.
// ----------------------------------------------------------------------------
module mts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                req_type,
  input  mts_pkg::dp_status_t status,
  output mts_pkg::dp_cmd_t    cmd
);
  import mts_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_POP_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // Take a request only when idle and the result register can take its result
  assign in_stall = !((state_r == ST_IDLE) && status.out_free);
  assign accept   = in_valid && !in_stall;

  // Operation decode
  always_comb begin
    state_nxt = state_r;
    cmd.op    = CMD_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (req_type == REQ_PUSH) begin
            cmd.op = status.full ? CMD_PUSH_FULL : CMD_PUSH;
          end else if (status.empty) begin
            cmd.op = CMD_POP_EMPTY;
          end else if (status.one) begin
            cmd.op = CMD_POP_LAST;
          end else begin
            cmd.op    = CMD_POP_READ;
            state_nxt = ST_POP_WAIT;
          end
        end
      end
      ST_POP_WAIT: begin
        if (status.out_free) begin
          cmd.op    = CMD_POP_FINISH;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // No new request while a pop read is outstanding
  a_wait_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POP_WAIT |-> in_stall)
    else $error("request accepted during pop read");

  // A memory-fetching pop always moves to the wait state
  a_read_waits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == CMD_POP_READ |=> state_r == ST_POP_WAIT)
    else $error("pop read without wait state");

  // The wait ends as soon as the result register is free
  a_wait_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP_WAIT) && status.out_free |=> state_r == ST_IDLE)
    else $error("pop wait did not finish");

endmodule

### hdl/min_tracking_stack_top.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_top
// Signed 32-bit LIFO stack that reports top value and running minimum
// after every push or pop request.
//
//   Channel | Ports                          | Payload
//   --------+--------------------------------+------------------------------
//   request | in_valid, in_stall, in_data    | req_type, push_value
//   result  | out_valid, out_stall, out_data | top_value, min_value,
//           |                                | is_empty, fault
//
// A push, a pop of the last entry and any faulting request load the result
// register directly. A pop that leaves entries behind also passes through the
// pop wait state: the new top comes from the entry memory through its registered read port.
// Reset clears the entry count, the result valid and the sequencer state;
// the memory needs no clearing pass.
// One result register parts the channels; every request needs it, so a
// stalled result holds and blocks the next transfer until it is taken.
// ----------------------------------------------------------------------------
module min_tracking_stack_top #(
  parameter int unsigned STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mts_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mts_pkg::res_t out_data
);
  import mts_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Request sequencer
  mts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (in_data.req_type),
    .status   (status),
    .cmd      (cmd)
  );

  // Stack storage and result register
  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .req       (in_data),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
